[sv/jtl_pkg.sv]
// shared types, codes and helpers for the json token lexer
`default_nettype none

package jtl_pkg;

  localparam int POS_BITS_DEF = 32;
  localparam int TOK_BITS     = 32;
  localparam int MAX_RES      = 3;
  localparam int FIFO_DEPTH   = 4;  // power of two
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);

  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  localparam logic [15:0] CP_TWO_BYTE   = 16'h0080;
  localparam logic [15:0] CP_THREE_BYTE = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2    = 8'b1100_0000;
  localparam logic [7:0]  UTF8_LEAD3    = 8'b1110_0000;
  localparam logic [7:0]  UTF8_CONT     = 8'b1000_0000;

  localparam logic [2:0] HEX_DIGITS = 3'd4;

  typedef enum logic [1:0] {
    MODE_IDLE = 2'd0,
    MODE_STR  = 2'd1,
    MODE_ESC  = 2'd2,
    MODE_HEX  = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    K_CONTENT  = 4'd0,
    K_STR_END  = 4'd1,
    K_LBRACE   = 4'd2,
    K_RBRACE   = 4'd3,
    K_LBRACKET = 4'd4,
    K_RBRACKET = 4'd5,
    K_COMMA    = 4'd6,
    K_COLON    = 4'd7,
    K_EOF      = 4'd8,
    K_INVALID  = 4'd9
  } kind_t;

  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_UNEXPECT = 3'd1,
    E_NO_CLOSE = 3'd2,
    E_BAD_HEX  = 3'd3,
    E_BAD_ESC  = 3'd4,
    E_CTRL     = 3'd5
  } err_t;

  typedef struct packed {
    kind_t               kind;
    logic [7:0]          data;
    err_t                err;
    logic [TOK_BITS-1:0] start;
  } res_t;

  typedef struct packed {
    logic [1:0]             cnt;
    res_t [MAX_RES-1:0]     slot;
  } group_t;

  function automatic res_t mk_res(kind_t kind, logic [7:0] data, err_t err,
                                  logic [TOK_BITS-1:0] start);
    res_t r;
    r.kind  = kind;
    r.data  = data;
    r.err   = err;
    r.start = start;
    return r;
  endfunction

  // {valid, value}
  function automatic logic [4:0] hex_value(logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

  // {valid, decoded byte}
  function automatic logic [8:0] simple_escape(logic [7:0] c);
    logic [8:0] r;
    unique case (c)
      CH_QUOTE:  r = {1'b1, CH_QUOTE};
      CH_BSLASH: r = {1'b1, CH_BSLASH};
      CH_SLASH:  r = {1'b1, CH_SLASH};
      8'h62:     r = {1'b1, 8'h08};
      8'h66:     r = {1'b1, 8'h0C};
      8'h6E:     r = {1'b1, 8'h0A};
      8'h72:     r = {1'b1, 8'h0D};
      8'h74:     r = {1'b1, 8'h09};
      default:   r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

[sv/jtl_core.sv]
// lexer state and per-byte decode into a group of up to three results
`default_nettype none

module jtl_core
  import jtl_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  input  wire logic       in_ready,
  input  wire logic [7:0] in_byte,
  input  wire logic       in_is_end,
  output logic            push,
  output group_t          grp
);

  mode_t                    mode_r, mode_nxt;
  logic [2:0]               hex_left_r, hex_left_nxt;
  logic [15:0]              acc_r, acc_nxt;
  logic [POSITION_BITS-1:0] pos_r, pos_nxt;
  logic [POSITION_BITS-1:0] ss_r, ss_nxt;

  logic                accept;
  logic [TOK_BITS-1:0] pos_tok;
  logic [TOK_BITS-1:0] ss_tok;
  logic [4:0]          hex;
  logic [8:0]          esc;
  logic [2:0]          hex_dec;
  logic                hex_done;
  logic [15:0]         cp;

  assign accept   = in_valid && in_ready;
  assign pos_tok  = TOK_BITS'(pos_r);
  assign ss_tok   = TOK_BITS'(ss_r);
  assign hex      = hex_value(in_byte);
  assign esc      = simple_escape(in_byte);
  assign hex_dec  = hex_left_r - 3'd1;
  assign hex_done = (hex_dec == 3'd0) || (hex_dec > HEX_DIGITS);
  assign cp       = {acc_r[11:0], hex[3:0]};

  // next state
  always_comb begin
    mode_nxt     = mode_r;
    hex_left_nxt = hex_left_r;
    acc_nxt      = acc_r;
    pos_nxt      = pos_r;
    ss_nxt       = ss_r;
    if (in_is_end) begin
      mode_nxt     = MODE_IDLE;
      hex_left_nxt = 3'd0;
    end else begin
      pos_nxt = pos_r + 1'b1;
      unique case (mode_r)
        MODE_IDLE: begin
          if (in_byte == CH_QUOTE) begin
            ss_nxt   = pos_r;
            mode_nxt = MODE_STR;
          end
        end
        MODE_STR: begin
          if (in_byte == CH_QUOTE || in_byte < CH_SPACE) begin
            mode_nxt = MODE_IDLE;
          end else if (in_byte == CH_BSLASH) begin
            mode_nxt = MODE_ESC;
          end
        end
        MODE_ESC: begin
          if (in_byte == CH_LOW_U) begin
            mode_nxt     = MODE_HEX;
            hex_left_nxt = HEX_DIGITS;
            acc_nxt      = 16'd0;
          end else if (esc[8]) begin
            mode_nxt = MODE_STR;
          end else begin
            mode_nxt = MODE_IDLE;
          end
        end
        MODE_HEX: begin
          if (!hex[4]) begin
            mode_nxt     = MODE_IDLE;
            hex_left_nxt = 3'd0;
          end else begin
            acc_nxt = cp;
            if (hex_done) begin
              hex_left_nxt = 3'd0;
              mode_nxt     = MODE_STR;
            end else begin
              hex_left_nxt = hex_dec;
            end
          end
        end
        default: mode_nxt = MODE_IDLE;
      endcase
    end
  end

  // result group
  always_comb begin
    grp = '0;
    if (in_is_end) begin
      if (mode_r != MODE_IDLE) begin
        grp.cnt     = 2'd2;
        grp.slot[0] = mk_res(K_INVALID, 8'd0, E_NO_CLOSE, ss_tok);
        grp.slot[1] = mk_res(K_EOF, 8'd0, E_NONE, pos_tok);
      end else begin
        grp.cnt     = 2'd1;
        grp.slot[0] = mk_res(K_EOF, 8'd0, E_NONE, pos_tok);
      end
    end else begin
      unique case (mode_r)
        MODE_IDLE: begin
          grp.cnt = 2'd1;
          unique case (in_byte)
            CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_QUOTE: grp.cnt = 2'd0;
            CH_LBRACE: grp.slot[0] = mk_res(K_LBRACE, 8'd0, E_NONE, pos_tok);
            CH_RBRACE: grp.slot[0] = mk_res(K_RBRACE, 8'd0, E_NONE, pos_tok);
            CH_LBRACK: grp.slot[0] = mk_res(K_LBRACKET, 8'd0, E_NONE, pos_tok);
            CH_RBRACK: grp.slot[0] = mk_res(K_RBRACKET, 8'd0, E_NONE, pos_tok);
            CH_COMMA:  grp.slot[0] = mk_res(K_COMMA, 8'd0, E_NONE, pos_tok);
            CH_COLON:  grp.slot[0] = mk_res(K_COLON, 8'd0, E_NONE, pos_tok);
            default:   grp.slot[0] = mk_res(K_INVALID, 8'd0, E_UNEXPECT, pos_tok);
          endcase
        end
        MODE_STR: begin
          grp.cnt = 2'd1;
          if (in_byte == CH_QUOTE) begin
            grp.slot[0] = mk_res(K_STR_END, 8'd0, E_NONE, ss_tok);
          end else if (in_byte == CH_BSLASH) begin
            grp.cnt = 2'd0;
          end else if (in_byte < CH_SPACE) begin
            grp.slot[0] = mk_res(K_INVALID, 8'd0, E_CTRL, ss_tok);
          end else begin
            grp.slot[0] = mk_res(K_CONTENT, in_byte, E_NONE, ss_tok);
          end
        end
        MODE_ESC: begin
          grp.cnt = 2'd1;
          if (in_byte == CH_LOW_U) begin
            grp.cnt = 2'd0;
          end else if (esc[8]) begin
            grp.slot[0] = mk_res(K_CONTENT, esc[7:0], E_NONE, ss_tok);
          end else begin
            grp.slot[0] = mk_res(K_INVALID, 8'd0, E_BAD_ESC, ss_tok);
          end
        end
        MODE_HEX: begin
          if (!hex[4]) begin
            grp.cnt     = 2'd1;
            grp.slot[0] = mk_res(K_INVALID, 8'd0, E_BAD_HEX, ss_tok);
          end else if (hex_done) begin
            if (cp < CP_TWO_BYTE) begin
              grp.cnt     = 2'd1;
              grp.slot[0] = mk_res(K_CONTENT, cp[7:0], E_NONE, ss_tok);
            end else if (cp < CP_THREE_BYTE) begin
              grp.cnt     = 2'd2;
              grp.slot[0] = mk_res(K_CONTENT, UTF8_LEAD2 | {3'd0, cp[10:6]}, E_NONE, ss_tok);
              grp.slot[1] = mk_res(K_CONTENT, UTF8_CONT | {2'd0, cp[5:0]}, E_NONE, ss_tok);
            end else begin
              grp.cnt     = 2'd3;
              grp.slot[0] = mk_res(K_CONTENT, UTF8_LEAD3 | {4'd0, cp[15:12]}, E_NONE, ss_tok);
              grp.slot[1] = mk_res(K_CONTENT, UTF8_CONT | {2'd0, cp[11:6]}, E_NONE, ss_tok);
              grp.slot[2] = mk_res(K_CONTENT, UTF8_CONT | {2'd0, cp[5:0]}, E_NONE, ss_tok);
            end
          end
        end
        default: grp.cnt = 2'd0;
      endcase
    end
  end

  assign push = accept && (grp.cnt != 2'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_IDLE;
      hex_left_r <= 3'd0;
      acc_r      <= 16'd0;
      pos_r      <= '0;
      ss_r       <= '0;
    end else if (accept) begin
      mode_r     <= mode_nxt;
      hex_left_r <= hex_left_nxt;
      acc_r      <= acc_nxt;
      pos_r      <= pos_nxt;
      ss_r       <= ss_nxt;
    end
  end

endmodule

`default_nettype wire

[sv/jtl_out_buf.sv]
// result group queue that hands out one result per request
`default_nettype none

module jtl_out_buf
  import jtl_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    push,
  input  wire group_t  grp,
  output logic         full,
  output logic         out_valid,
  input  wire logic    out_ready,
  output res_t         res,
  output logic         res_last
);

  group_t               mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [FIFO_AW:0]     count_r, count_nxt;
  logic [1:0]           sub_r;
  group_t               head;
  logic                 take;
  logic                 pop;

  assign head      = mem[rd_ptr_r];
  assign full      = (count_r == (FIFO_AW + 1)'(FIFO_DEPTH));
  assign out_valid = (count_r != '0);
  assign res_last  = ((sub_r + 2'd1) == head.cnt);
  assign take      = out_valid && out_ready;
  assign pop       = take && res_last;

  always_comb begin
    unique case (sub_r)
      2'd1:    res = head.slot[1];
      2'd2:    res = head.slot[2];
      default: res = head.slot[0];
    endcase
  end

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= grp;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      sub_r    <= 2'd0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
        sub_r    <= 2'd0;
      end else if (take) begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

[sv/json_token_lexer.sv]
// json token lexer top level: byte decode followed by a result queue
//
// Input channel in_*: one source byte per request, or an end marker when
// in_is_end is high. Output channel out_*: one token or decoded string byte
// per request, each with kind, byte, error code, start offset and a flag on
// the last result caused by its source request.
// A request is taken on every cycle while in_ready is high; the byte is
// decoded in the cycle it arrives and its results are written to the queue.
// A request yields zero to three results; the queue holds four groups, and
// the out side moves one result per cycle while out_ready is high, so the
// block keeps one source byte per cycle as long as three-byte code points
// stay spaced by their escape sequence. in_ready drops only when the queue
// is full, which happens when the receiver stalls out_ready; held results
// stay stable. Synchronous reset returns the lexer to idle outside any
// string, clears the position counter and empties the queue.
`default_nettype none

module json_token_lexer
  import jtl_pkg::*;
#(
  parameter int POSITION_BITS = POS_BITS_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic [7:0]          in_byte,
  input  wire logic                in_is_end,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [3:0]               out_kind,
  output logic [7:0]               out_byte,
  output logic [2:0]               out_error_code,
  output logic [TOK_BITS-1:0]      out_token_start,
  output logic                     out_last
);

  logic   push;
  logic   full;
  group_t grp;
  res_t   res;

  assign in_ready = !full;

  jtl_core #(
    .POSITION_BITS(POSITION_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_is_end (in_is_end),
    .push      (push),
    .grp       (grp)
  );

  jtl_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .grp       (grp),
    .full      (full),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .res       (res),
    .res_last  (out_last)
  );

  assign out_kind        = res.kind;
  assign out_byte        = res.data;
  assign out_error_code  = res.err;
  assign out_token_start = res.start;

  a_full_has_output: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid)
    else $error("queue full with nothing to send");

  a_token_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_CONTENT && out_kind != K_INVALID |-> out_last)
    else $error("token result not marked last");

  a_byte_only_content: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_CONTENT |-> out_byte == 8'd0)
    else $error("byte set on non-content result");

  a_err_only_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_kind == K_INVALID) == (out_error_code != E_NONE)))
    else $error("error code does not match kind");

endmodule

`default_nettype wire

[tb/json_token_lexer_test.sv]
// self-checking testbench for the json token lexer with a token scoreboard
`default_nettype none

module json_token_lexer_test;
  import jtl_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int PHASE_ITEMS = 36;
  localparam int HOLD_CYCLES = 60;

  localparam logic [7:0] CH_BS_CODE = 8'h08;

  typedef struct {
    kind_t               kind;
    logic [7:0]          data;
    err_t                err;
    logic [TOK_BITS-1:0] start;
    logic                last;
  } lex_token_t;

  class token_ledger;
    mode_t               mode;
    logic [2:0]          hex_left;
    logic [15:0]         cp_acc;
    logic [TOK_BITS-1:0] byte_pos;
    logic [TOK_BITS-1:0] str_start;
    lex_token_t          pending_tokens[$];
    int                  mismatches;

    function new();
      mode       = MODE_IDLE;
      hex_left   = 3'd0;
      cp_acc     = 16'd0;
      byte_pos   = '0;
      str_start  = '0;
      mismatches = 0;
    endfunction

    static function int hex_digit(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c - "0");
      if (c >= "a" && c <= "f") return int'(c - "a") + 10;
      if (c >= "A" && c <= "F") return int'(c - "A") + 10;
      return -1;
    endfunction

    static function int unescape(logic [7:0] c);
      case (c)
        CH_QUOTE:  return int'(CH_QUOTE);
        CH_BSLASH: return int'(CH_BSLASH);
        CH_SLASH:  return int'(CH_SLASH);
        "b":       return int'(CH_BS_CODE);
        "f":       return 12;
        "n":       return int'(CH_LF);
        "r":       return int'(CH_CR);
        "t":       return int'(CH_TAB);
        default:   return -1;
      endcase
    endfunction

    function void push(kind_t k, logic [7:0] d, err_t e, logic [TOK_BITS-1:0] s);
      lex_token_t t;
      t.kind  = k;
      t.data  = d;
      t.err   = e;
      t.start = s;
      t.last  = 1'b0;
      pending_tokens.insert(pending_tokens.size(), t);
    endfunction

    // returns 1 when the request is whitespace skipped outside strings
    function bit lex_request(logic [7:0] c, logic at_end);
      int                  first;
      int                  d;
      int                  esc;
      bit                  skipped;
      logic [TOK_BITS-1:0] pos;
      first   = pending_tokens.size();
      pos     = byte_pos;
      skipped = 1'b0;
      if (at_end) begin
        if (mode != MODE_IDLE) push(K_INVALID, 8'h00, E_NO_CLOSE, str_start);
        push(K_EOF, 8'h00, E_NONE, pos);
        mode     = MODE_IDLE;
        hex_left = 3'd0;
      end else begin
        byte_pos = pos + 1'b1;
        case (mode)
          MODE_IDLE: begin
            case (c)
              CH_SPACE, CH_TAB, CH_LF, CH_CR: skipped = 1'b1;
              CH_QUOTE: begin
                str_start = pos;
                mode      = MODE_STR;
              end
              CH_LBRACE: push(K_LBRACE, 8'h00, E_NONE, pos);
              CH_RBRACE: push(K_RBRACE, 8'h00, E_NONE, pos);
              CH_LBRACK: push(K_LBRACKET, 8'h00, E_NONE, pos);
              CH_RBRACK: push(K_RBRACKET, 8'h00, E_NONE, pos);
              CH_COMMA:  push(K_COMMA, 8'h00, E_NONE, pos);
              CH_COLON:  push(K_COLON, 8'h00, E_NONE, pos);
              default:   push(K_INVALID, 8'h00, E_UNEXPECT, pos);
            endcase
          end
          MODE_STR: begin
            if (c == CH_QUOTE) begin
              push(K_STR_END, 8'h00, E_NONE, str_start);
              mode = MODE_IDLE;
            end else if (c == CH_BSLASH) begin
              mode = MODE_ESC;
            end else if (c < CH_SPACE) begin
              push(K_INVALID, 8'h00, E_CTRL, str_start);
              mode = MODE_IDLE;
            end else begin
              push(K_CONTENT, c, E_NONE, str_start);
            end
          end
          MODE_ESC: begin
            esc = unescape(c);
            if (c == CH_LOW_U) begin
              mode     = MODE_HEX;
              hex_left = HEX_DIGITS;
              cp_acc   = 16'd0;
            end else if (esc < 0) begin
              push(K_INVALID, 8'h00, E_BAD_ESC, str_start);
              mode = MODE_IDLE;
            end else begin
              push(K_CONTENT, 8'(esc), E_NONE, str_start);
              mode = MODE_STR;
            end
          end
          default: begin
            d = hex_digit(c);
            if (d < 0) begin
              push(K_INVALID, 8'h00, E_BAD_HEX, str_start);
              mode     = MODE_IDLE;
              hex_left = 3'd0;
            end else begin
              cp_acc   = {cp_acc[11:0], 4'(d)};
              hex_left = hex_left - 3'd1;
              if (hex_left == 3'd0) begin
                mode = MODE_STR;
                if (cp_acc < CP_TWO_BYTE) begin
                  push(K_CONTENT, cp_acc[7:0], E_NONE, str_start);
                end else if (cp_acc < CP_THREE_BYTE) begin
                  push(K_CONTENT, UTF8_LEAD2 | {3'b000, cp_acc[10:6]}, E_NONE, str_start);
                  push(K_CONTENT, UTF8_CONT | {2'b00, cp_acc[5:0]}, E_NONE, str_start);
                end else begin
                  push(K_CONTENT, UTF8_LEAD3 | {4'b0000, cp_acc[15:12]}, E_NONE, str_start);
                  push(K_CONTENT, UTF8_CONT | {2'b00, cp_acc[11:6]}, E_NONE, str_start);
                  push(K_CONTENT, UTF8_CONT | {2'b00, cp_acc[5:0]}, E_NONE, str_start);
                end
              end
            end
          end
        endcase
      end
      if (pending_tokens.size() > first)
        pending_tokens[pending_tokens.size() - 1].last = 1'b1;
      return skipped;
    endfunction

    function void match_token(logic [3:0] kind, logic [7:0] data, logic [2:0] err,
                              logic [TOK_BITS-1:0] start, logic last);
      lex_token_t want;
      if (pending_tokens.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: kind %0d byte %02h err %0d start %0d last %0b",
                   kind, data, err, start, last);
        return;
      end
      want = pending_tokens.pop_front();
      if (kind !== want.kind || data !== want.data || err !== want.err ||
          start !== want.start || last !== want.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"mismatch: expected kind %0d byte %02h err %0d start %0d last %0b, ",
                    "got kind %0d byte %02h err %0d start %0d last %0b"},
                   want.kind, want.data, want.err, want.start, want.last,
                   kind, data, err, start, last);
      end
    endfunction

    function int pending();
      return pending_tokens.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [7:0]          in_byte = 8'h00;
  logic                in_is_end = 1'b0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [3:0]          out_kind;
  logic [7:0]          out_byte;
  logic [2:0]          out_error_code;
  logic [TOK_BITS-1:0] out_token_start;
  logic                out_last;

  token_ledger ledger;
  int          idle_pct = 0;
  int          stall_pct = 0;
  int          hold_left = 0;
  int          lexed_items = 0;
  int          cycle_count = 0;

  logic [7:0] punct_chars [6] = '{CH_LBRACE, CH_RBRACE, CH_LBRACK, CH_RBRACK,
                                   CH_COMMA, CH_COLON};
  logic [7:0] blank_chars [4] = '{CH_SPACE, CH_TAB, CH_LF, CH_CR};
  logic [7:0] escape_chars [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, "b", "f", "n", "r", "t"};

  json_token_lexer dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_byte         (in_byte),
    .in_is_end       (in_is_end),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_byte        (out_byte),
    .out_error_code  (out_error_code),
    .out_token_start (out_token_start),
    .out_last        (out_last)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // receiver: random stalls plus long hold-offs counted here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      ledger.match_token(out_kind, out_byte, out_error_code, out_token_start, out_last);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: failure");
    $finish;
  end

  task automatic send_req(logic [7:0] b, logic at_end);
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_byte   <= b;
    in_is_end <= at_end;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (!ledger.lex_request(b, at_end)) lexed_items++;
  endtask

  task automatic send_byte(logic [7:0] b);
    send_req(b, 1'b0);
  endtask

  task automatic send_end();
    send_req(8'($urandom), 1'b1);
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic wait_for_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0") + 8'(n);
    return ($urandom_range(1) ? 8'("a") : 8'("A")) + 8'(n) - 8'd10;
  endfunction

  task automatic send_hex_digits(int count);
    repeat (count) send_byte(hex_char(4'($urandom)));
  endtask

  task automatic send_unicode();
    logic [15:0] cp;
    case ($urandom_range(2))
      0: cp = 16'($urandom_range(16'h007F));
      1: cp = 16'($urandom_range(16'h07FF, 16'h0080));
      default: cp = 16'($urandom_range(16'hFFFF, 16'h0800));
    endcase
    send_text("\\u");
    for (int i = 3; i >= 0; i--) send_byte(hex_char(cp[i*4 +: 4]));
  endtask

  task automatic send_string_body(int len);
    logic [7:0] c;
    repeat (len) begin
      case ($urandom_range(9))
        0, 1: begin
          send_byte(CH_BSLASH);
          send_byte(escape_chars[$urandom_range(7)]);
        end
        2, 3: send_unicode();
        default: begin
          do c = 8'($urandom_range(8'hFF, 8'h20));
          while (c == CH_QUOTE || c == CH_BSLASH);
          send_byte(c);
        end
      endcase
    end
  endtask

  task automatic send_broken_string();
    logic [7:0] c;
    send_byte(CH_QUOTE);
    send_string_body($urandom_range(3));
    case ($urandom_range(3))
      0: send_byte(8'($urandom_range(8'h1F)));
      1: begin
        send_byte(CH_BSLASH);
        do c = 8'($urandom);
        while (token_ledger::unescape(c) >= 0 || c == CH_LOW_U);
        send_byte(c);
      end
      2: begin
        send_text("\\u");
        send_hex_digits($urandom_range(3));
        do c = 8'($urandom);
        while (token_ledger::hex_digit(c) >= 0);
        send_byte(c);
      end
      default: begin
        case ($urandom_range(2))
          1: send_byte(CH_BSLASH);
          2: begin
            send_text("\\u");
            send_hex_digits($urandom_range(3));
          end
          default: begin end
        endcase
        send_end();
      end
    endcase
  endtask

  task automatic send_random_token();
    int pick;
    pick = $urandom_range(99);
    if (pick < 25) begin
      send_byte(punct_chars[$urandom_range(5)]);
    end else if (pick < 35) begin
      send_byte(blank_chars[$urandom_range(3)]);
    end else if (pick < 75) begin
      send_byte(CH_QUOTE);
      send_string_body($urandom_range(6));
      send_byte(CH_QUOTE);
    end else if (pick < 87) begin
      send_broken_string();
    end else if (pick < 95) begin
      send_byte(8'($urandom));
    end else begin
      send_end();
    end
  endtask

  initial begin
    int idle_mix [4];
    int stall_mix [4];
    int target;
    idle_mix  = '{0, 80, 0, 7};
    stall_mix = '{0, 0, 80, 7};
    ledger = new();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed: tokens, stray bytes, end markers, strings and their errors
    send_text("{}[],:");
    send_byte(8'h00);
    send_end();
    send_end();
    send_byte(CH_QUOTE);
    send_byte(8'hFF);
    send_text("\\uD8fF\\u0000\"");
    send_byte(CH_QUOTE);
    send_byte(8'h1F);
    send_text("\"\\x");
    send_text("\"\\ug");
    send_text("\"\\u0");
    send_end();
    wait_for_results();

    for (int p = 0; p < 4; p++) begin
      idle_pct  = idle_mix[p];
      stall_pct = stall_mix[p];
      if (p == 0) hold_left = HOLD_CYCLES;
      target = lexed_items + PHASE_ITEMS;
      while (lexed_items < target) send_random_token();
      wait_for_results();
    end

    repeat (20) @(posedge clk);
    if (ledger.mismatches == 0 && ledger.pending() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

`default_nettype wire
